@@ rtl/core/pfp_pkg.sv @@
`timescale 1ns / 1ps

package pfp_pkg;

  localparam int FrameLen = 9;
  localparam int TextLen  = 7;
  localparam int PosW     = 4;

  localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

  typedef logic [7:0] char_t;

  localparam char_t ChSemi  = 8'h3B;
  localparam char_t ChColon = 8'h3A;
  localparam char_t ChX     = 8'h78;
  localparam char_t ChZero  = 8'h30;
  localparam char_t ChNine  = 8'h39;
  localparam char_t ChNul   = 8'h00;
  localparam char_t ChE     = 8'h45;
  localparam char_t ChR     = 8'h52;
  localparam char_t ChO     = 8'h4F;
  localparam char_t ChBang  = 8'h21;

  typedef logic [FrameLen-1:0][7:0] frame_t;
  typedef logic [FrameLen-2:0][7:0] head_t;
  typedef logic [TextLen-1:0][7:0]  text_t;

  typedef struct packed {
    logic  ok;
    text_t text;
  } result_t;

endpackage

@@ rtl/core/pressure_frame_parser_top.sv @@
`timescale 1ns / 1ps
// Channel   Valid       Stall       Payload
// input     rx_valid    rx_stall    rx_byte
// output    text_valid  text_stall  frame_ok, text_char0 .. text_char6
//
// One byte is taken per cycle while rx_stall is low; every ninth byte closes a frame.
// A closed frame is held in the frame register, is checked and formatted
// combinationally, and lands in the output register, which drives the result.
// The frame register and output register give full rate while text_stall is low.
// Synchronous reset clears the byte position and both valid flags.
// rx_stall rises only while a finished frame waits and the output is stalled.

module pressure_frame_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       text_valid,
  input  logic       text_stall,
  output logic       frame_ok,
  output logic [7:0] text_char0,
  output logic [7:0] text_char1,
  output logic [7:0] text_char2,
  output logic [7:0] text_char3,
  output logic [7:0] text_char4,
  output logic [7:0] text_char5,
  output logic [7:0] text_char6
);
  import pfp_pkg::*;

  frame_t  frame;
  logic    frame_valid;
  logic    frame_taken;
  logic    load_ready;
  result_t result;
  result_t out_data;

  assign frame_taken = frame_valid && load_ready;

  pfp_collect u_collect (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .frame_taken (frame_taken),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  pfp_format u_format (
    .frame  (frame),
    .result (result)
  );

  pfp_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (frame_valid),
    .load_ready (load_ready),
    .load_data  (result),
    .out_valid  (text_valid),
    .out_stall  (text_stall),
    .out_data   (out_data)
  );

  assign frame_ok   = out_data.ok;
  assign text_char0 = out_data.text[0];
  assign text_char1 = out_data.text[1];
  assign text_char2 = out_data.text[2];
  assign text_char3 = out_data.text[3];
  assign text_char4 = out_data.text[4];
  assign text_char5 = out_data.text[5];
  assign text_char6 = out_data.text[6];

endmodule

@@ rtl/core/pfp_collect.sv @@
`timescale 1ns / 1ps

module pfp_collect (
  input  logic           clk,
  input  logic           rst,
  input  logic           rx_valid,
  output logic           rx_stall,
  input  pfp_pkg::char_t rx_byte,
  input  logic           frame_taken,
  output logic           frame_valid,
  output pfp_pkg::frame_t frame
);
  import pfp_pkg::*;

  logic [PosW-1:0] pos;
  head_t           head;
  logic            rx_xfer;
  logic            frame_valid_next;

  assign rx_stall = frame_valid && !frame_taken;
  assign rx_xfer  = rx_valid && !rx_stall;

  always_comb begin
    frame_valid_next = frame_valid && !frame_taken;
    if (rx_xfer && pos == LastPos) begin
      frame_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      frame_valid <= 1'b0;
    end else begin
      frame_valid <= frame_valid_next;
      if (rx_xfer) begin
        if (pos == LastPos) begin
          pos <= '0;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_xfer) begin
      if (pos == LastPos) begin
        frame <= {rx_byte, head};
      end else begin
        head[pos[PosW-2:0]] <= rx_byte;
      end
    end
  end

endmodule

@@ rtl/core/pfp_format.sv @@
`timescale 1ns / 1ps

module pfp_format (
  input  pfp_pkg::frame_t  frame,
  output pfp_pkg::result_t result
);
  import pfp_pkg::*;

  logic [5:0] digit_ok;
  logic       delim_ok;
  text_t      good_text;
  text_t      err_text;

  function automatic logic is_digit(input char_t c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  always_comb begin
    digit_ok[0] = is_digit(frame[1]);
    digit_ok[1] = is_digit(frame[2]);
    digit_ok[2] = is_digit(frame[3]);
    digit_ok[3] = is_digit(frame[5]);
    digit_ok[4] = is_digit(frame[6]);
    digit_ok[5] = is_digit(frame[7]);
    delim_ok    = (frame[0] == ChSemi) && (frame[4] == ChX) && (frame[8] == ChColon);

    for (int j = 0; j < TextLen; j++) begin
      good_text[j] = frame[j+1];
    end
    if (frame[5] == ChZero) begin
      good_text[4] = frame[6];
      good_text[5] = frame[7];
      good_text[6] = ChNul;
    end

    err_text[0] = ChE;
    err_text[1] = ChR;
    err_text[2] = ChR;
    err_text[3] = ChO;
    err_text[4] = ChBang;
    err_text[5] = ChNul;
    err_text[6] = ChNul;

    result.ok   = delim_ok && (&digit_ok);
    result.text = result.ok ? good_text : err_text;
  end

endmodule

@@ rtl/core/pfp_out.sv @@
`timescale 1ns / 1ps

module pfp_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  pfp_pkg::result_t load_data,
  output logic             out_valid,
  input  logic             out_stall,
  output pfp_pkg::result_t out_data
);
  import pfp_pkg::*;

  assign load_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule
